>>> rtl/stc_pkg.sv
package stc_pkg;

  // Field widths of the stream words.
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 5;
  localparam int POS_W      = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 7;

  // Most bytes one classification step can take, and most words one input byte can release.
  localparam int MAX_RES = 3;

  // Token kinds. Code zero also marks "no token open" in the open-kind register.
  localparam logic [KIND_W-1:0] K_NONE   = 5'd0;
  localparam logic [KIND_W-1:0] K_SKIP   = 5'd0;
  localparam logic [KIND_W-1:0] K_LL     = 5'd1;
  localparam logic [KIND_W-1:0] K_RR     = 5'd2;
  localparam logic [KIND_W-1:0] K_DOLLAR = 5'd3;
  localparam logic [KIND_W-1:0] K_BIND   = 5'd4;
  localparam logic [KIND_W-1:0] K_ARROW  = 5'd5;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd6;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd7;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd8;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd9;
  localparam logic [KIND_W-1:0] K_LBRACK = 5'd10;
  localparam logic [KIND_W-1:0] K_RBRACK = 5'd11;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd12;
  localparam logic [KIND_W-1:0] K_COLON  = 5'd13;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd14;
  localparam logic [KIND_W-1:0] K_EQUAL  = 5'd15;
  localparam logic [KIND_W-1:0] K_EOF    = 5'd16;
  localparam logic [KIND_W-1:0] K_STR    = 5'd17;
  localparam logic [KIND_W-1:0] K_NUM    = 5'd18;
  localparam logic [KIND_W-1:0] K_ID     = 5'd19;
  localparam logic [KIND_W-1:0] K_RAW    = 5'd20;
  localparam logic [KIND_W-1:0] K_BLANK  = 5'd21;

  // Scanner mode that carries from one byte to the next.
  typedef struct packed {
    logic [KIND_W-1:0] open_kind;
    logic [BYTE_W-1:0] quote_char;
    logic              escape_pending;
  } ctl_t;

  // Tags of one classified byte.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              start;
    logic              text;
  } res_t;

endpackage

>>> rtl/stc_take.sv
module stc_take #(
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16
) (
  input  stc_pkg::ctl_t                                   ctl_in,
  input  logic [LINE_WIDTH-1:0]                           line_in,
  input  logic [COLUMN_WIDTH-1:0]                         column_in,
  input  logic [LINE_WIDTH-1:0]                           start_line_in,
  input  logic [COLUMN_WIDTH-1:0]                         start_column_in,
  input  logic [stc_pkg::MAX_RES-1:0][stc_pkg::BYTE_W-1:0] window,
  input  logic [1:0]                                      avail,
  input  logic                                            at_end,
  output stc_pkg::ctl_t                                   ctl_out,
  output logic [LINE_WIDTH-1:0]                           line_out,
  output logic [COLUMN_WIDTH-1:0]                         column_out,
  output logic [LINE_WIDTH-1:0]                           start_line_out,
  output logic [COLUMN_WIDTH-1:0]                         start_column_out,
  output logic [1:0]                                      used,
  output stc_pkg::res_t [stc_pkg::MAX_RES-1:0]            res
);
  import stc_pkg::*;

  // Characters the scanner looks for.
  localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DQUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DOLLAR     = 8'h24;
  localparam logic [BYTE_W-1:0] CH_AMP        = 8'h26;
  localparam logic [BYTE_W-1:0] CH_SQUOTE     = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LPAREN     = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN     = 8'h29;
  localparam logic [BYTE_W-1:0] CH_COMMA      = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS      = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE       = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEMI       = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_EQUAL      = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_GT         = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LBRACK     = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_BSLASH     = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBRACK     = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_BQUOTE     = 8'h60;
  localparam logic [BYTE_W-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_LBRACE     = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE     = 8'h7D;

  function automatic logic is_blank(input logic [BYTE_W-1:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic logic is_letter(input logic [BYTE_W-1:0] ch);
    return (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) || (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
           ch == CH_UNDERSCORE;
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic logic is_quote(input logic [BYTE_W-1:0] ch);
    return ch == CH_DQUOTE || ch == CH_SQUOTE || ch == CH_BQUOTE;
  endfunction

  // Kind of a single punctuation byte, K_NONE for any other byte.
  function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] ch);
    logic [KIND_W-1:0] k;
    unique case (ch)
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_COMMA:  k = K_COMMA;
      CH_COLON:  k = K_COLON;
      CH_SEMI:   k = K_SEMI;
      CH_EQUAL:  k = K_EQUAL;
      default:   k = K_NONE;
    endcase
    return k;
  endfunction

  // A raw byte belongs to no other class; bytes 128 and up land here.
  function automatic logic is_raw(input logic [BYTE_W-1:0] ch);
    return ch != '0 && punct_kind(ch) == K_NONE && ch != CH_AMP && ch != CH_MINUS &&
           ch != CH_DOLLAR && !is_quote(ch) && !is_letter(ch) && !is_digit(ch) && !is_blank(ch);
  endfunction

  function automatic res_t mk_res(input logic [BYTE_W-1:0] d, input logic [KIND_W-1:0] k,
                                  input logic st, input logic tx);
    res_t r;
    r.data  = d;
    r.kind  = k;
    r.start = st;
    r.text  = tx;
    return r;
  endfunction

  logic [BYTE_W-1:0]       c;
  logic [BYTE_W-1:0]       l1;
  logic [BYTE_W-1:0]       l2;
  logic                    has1;
  logic                    has2;
  logic                    nl;
  logic                    cont;
  logic                    stall;
  logic [KIND_W-1:0]       pkind;
  logic [LINE_WIDTH-1:0]   line_c;
  logic [COLUMN_WIDTH-1:0] column_c;
  logic [COLUMN_WIDTH:0]   column_sum;

  // Byte classes and lookahead; missing lookahead reads as zero.
  always_comb begin
    c     = window[0];
    l1    = (avail > 2'd1) ? window[1] : '0;
    l2    = (avail == 2'd3) ? window[2] : '0;
    has1  = (avail > 2'd1) || at_end;
    has2  = (avail == 2'd3) || at_end;
    nl    = c == CH_NEWLINE;
    pkind = punct_kind(c);
    cont  = (ctl_in.open_kind == K_NUM && (is_digit(c) || c == CH_DOT)) ||
            (ctl_in.open_kind == K_ID && (is_letter(c) || is_digit(c))) ||
            (ctl_in.open_kind == K_RAW && is_raw(c));
    stall = ((c == CH_LBRACE || c == CH_RBRACE || c == CH_MINUS) && !has1) ||
            (c == CH_AMP && (!has1 || (l1 == CH_MINUS && !has2)));
  end

  // Position counters after the first byte alone, used for a new token's position.
  always_comb begin
    if (nl) begin
      line_c   = (line_in == '1) ? line_in : line_in + LINE_WIDTH'(1);
      column_c = '0;
    end else begin
      line_c   = line_in;
      column_c = (column_in == '1) ? column_in : column_in + COLUMN_WIDTH'(1);
    end
  end

  // Classify the byte at the head of the window.
  always_comb begin
    ctl_out          = ctl_in;
    start_line_out   = start_line_in;
    start_column_out = start_column_in;
    used             = 2'd0;
    res              = '0;
    if (avail != 2'd0) begin
      if (ctl_in.open_kind == K_STR) begin
        used = 2'd1;
        if (ctl_in.escape_pending) begin
          ctl_out.escape_pending = 1'b0;
          res[0] = mk_res(c, K_STR, 1'b0, 1'b1);
        end else if (c == ctl_in.quote_char) begin
          ctl_out.open_kind = K_NONE;
          res[0] = mk_res(c, K_STR, 1'b0, 1'b0);
        end else begin
          if (c == CH_BSLASH) begin
            ctl_out.escape_pending = 1'b1;
          end
          res[0] = mk_res(c, K_STR, 1'b0, 1'b1);
        end
      end else if (cont) begin
        used = 2'd1;
        res[0] = mk_res(c, ctl_in.open_kind, 1'b0, 1'b1);
      end else if (!stall) begin
        // A new token; a blank run keeps the position of its first blank.
        if (ctl_in.open_kind != K_BLANK) begin
          start_line_out   = line_c;
          start_column_out = column_c;
        end
        ctl_out.open_kind = K_NONE;
        used = 2'd1;
        if (is_blank(c)) begin
          ctl_out.open_kind = K_BLANK;
          res[0] = mk_res(c, K_SKIP, 1'b0, 1'b0);
        end else if ((c == CH_LBRACE || c == CH_RBRACE) && l1 == c) begin
          used   = 2'd2;
          res[0] = mk_res(c, (c == CH_LBRACE) ? K_LL : K_RR, 1'b1, 1'b1);
          res[1] = mk_res(l1, (c == CH_LBRACE) ? K_LL : K_RR, 1'b0, 1'b1);
        end else if (c == CH_DOLLAR) begin
          res[0] = mk_res(c, K_DOLLAR, 1'b1, 1'b1);
        end else if (c == CH_AMP && l1 == CH_MINUS && l2 == CH_GT) begin
          used   = 2'd3;
          res[0] = mk_res(c, K_BIND, 1'b1, 1'b1);
          res[1] = mk_res(l1, K_BIND, 1'b0, 1'b1);
          res[2] = mk_res(l2, K_BIND, 1'b0, 1'b1);
        end else if (c == CH_MINUS && l1 == CH_GT) begin
          used   = 2'd2;
          res[0] = mk_res(c, K_ARROW, 1'b1, 1'b1);
          res[1] = mk_res(l1, K_ARROW, 1'b0, 1'b1);
        end else if (pkind != K_NONE) begin
          res[0] = mk_res(c, pkind, 1'b1, 1'b1);
        end else if (is_quote(c)) begin
          ctl_out.open_kind      = K_STR;
          ctl_out.quote_char     = c;
          ctl_out.escape_pending = 1'b0;
          res[0] = mk_res(c, K_STR, 1'b1, 1'b0);
        end else if (is_digit(c)) begin
          ctl_out.open_kind = K_NUM;
          res[0] = mk_res(c, K_NUM, 1'b1, 1'b1);
        end else if (is_letter(c)) begin
          ctl_out.open_kind = K_ID;
          res[0] = mk_res(c, K_ID, 1'b1, 1'b1);
        end else if (is_raw(c)) begin
          ctl_out.open_kind = K_RAW;
          res[0] = mk_res(c, K_RAW, 1'b1, 1'b1);
        end else begin
          // A lone ampersand or minus is a one-byte raw token.
          res[0] = mk_res(c, K_RAW, 1'b1, 1'b1);
        end
      end
    end
  end

  // Counters after all bytes taken; only the first byte can be a newline.
  always_comb begin
    column_sum = {1'b0, column_in} + (COLUMN_WIDTH+1)'(used);
    if (used == 2'd0) begin
      line_out   = line_in;
      column_out = column_in;
    end else if (nl) begin
      line_out   = line_c;
      column_out = COLUMN_WIDTH'(used - 2'd1);
    end else begin
      line_out   = line_c;
      column_out = column_sum[COLUMN_WIDTH] ? '1 : column_sum[COLUMN_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/script_token_classifier_core.sv
// Streaming tokenizer for script text. Each input word carries one source byte, or an end mark;
// a zero byte also ends the stream. Every byte leaves as one output word tagged with its token
// kind, a token-start flag, a text flag and the token's saturating line and column; the end of
// the stream adds one end-of-file word and returns the block to its reset state. Up to two
// bytes are held back as lookahead for the "{{", "}}", "->" and "&->" tokens, so a byte may
// leave several input words later, and tlast marks the last output word that an input word
// releases (an input word may release none). An input word is registered, then classified
// and its words written into the output queue once the queue has room. The block takes one
// input word per cycle as long as the 8-entry output queue has three free entries, and drains
// that queue one word per cycle while m_axis_tready is high; since each byte yields one output
// word, the sustained rate is one byte per cycle.
module script_token_classifier_core #(
  parameter int LINE_WIDTH   = 16,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [stc_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] in_byte
  input  logic [stc_pkg::IN_USER_W-1:0]    s_axis_tuser,  // [0] end_mark
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [stc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [7:0] out_byte, [23:8] token_line,
                                                          // [39:24] token_column
  output logic [stc_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [4:0] token_kind, [5] token_start,
                                                          // [6] in_text
  output logic                             m_axis_tlast   // run_last
);
  import stc_pkg::*;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    res_t             res;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic             last;
  } word_t;

  // Input register.
  logic              in_full;
  logic [BYTE_W-1:0] in_data;
  logic              in_end;
  logic              accept;
  logic              take_item;
  logic              space_ok;

  // Scanner state.
  logic [MAX_RES-2:0][BYTE_W-1:0] held_bytes;
  logic [MAX_RES-2:0][BYTE_W-1:0] held_bytes_next;
  logic [1:0]                     held_count;
  logic [1:0]                     held_count_next;
  logic [LINE_WIDTH-1:0]          line_count;
  logic [LINE_WIDTH-1:0]          line_count_next;
  logic [COLUMN_WIDTH-1:0]        column_count;
  logic [COLUMN_WIDTH-1:0]        column_count_next;
  ctl_t                           ctl;
  ctl_t                           ctl_next;
  logic [LINE_WIDTH-1:0]          start_line;
  logic [LINE_WIDTH-1:0]          start_line_next;
  logic [COLUMN_WIDTH-1:0]        start_column;
  logic [COLUMN_WIDTH-1:0]        start_column_next;

  // Bytes under classification this cycle.
  logic [MAX_RES-1:0][BYTE_W-1:0] pend;
  logic [MAX_RES-1:0][BYTE_W-1:0] rest;
  logic [1:0]                     np;
  logic                           at_end;

  // Chain of classification steps.
  ctl_t                           ctl_chain    [MAX_RES+1];
  logic [LINE_WIDTH-1:0]          line_chain   [MAX_RES+1];
  logic [COLUMN_WIDTH-1:0]        column_chain [MAX_RES+1];
  logic [LINE_WIDTH-1:0]          sline_chain  [MAX_RES+1];
  logic [COLUMN_WIDTH-1:0]        scol_chain   [MAX_RES+1];
  logic [1:0]                     pos_chain    [MAX_RES+1];
  logic [1:0]                     used_chain   [MAX_RES];
  logic [1:0]                     avail_chain  [MAX_RES];
  logic [MAX_RES-1:0][BYTE_W-1:0] win_chain    [MAX_RES];
  res_t [MAX_RES-1:0]             res_chain    [MAX_RES];

  // Output words of this cycle.
  res_t [MAX_RES-1:0]                   slot_res;
  logic [MAX_RES-1:0][LINE_WIDTH-1:0]   slot_line;
  logic [MAX_RES-1:0][COLUMN_WIDTH-1:0] slot_column;
  word_t [MAX_RES-1:0]                  slot_word;
  logic [1:0]                           n_res;
  logic [COLUMN_WIDTH:0]                end_sum;
  logic [COLUMN_WIDTH-1:0]              end_column;

  // Output queue.
  word_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   fifo_count;
  logic [FIFO_CW-1:0]   fifo_count_next;
  logic                 pop;
  word_t                head;

  // Handshakes: the input register refills whenever its word moves on.
  assign space_ok      = fifo_count <= FIFO_CW'(FIFO_DEPTH - MAX_RES);
  assign take_item     = in_full && space_ok;
  assign s_axis_tready = !in_full || space_ok;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // Held bytes followed by the new byte, unless the stream ends here.
  always_comb begin
    at_end = in_end || (in_data == '0);
    pend   = '0;
    unique case (held_count)
      2'd0: begin
        pend[0] = in_data;
      end
      2'd1: begin
        pend[0] = held_bytes[0];
        pend[1] = in_data;
      end
      default: begin
        pend[0] = held_bytes[0];
        pend[1] = held_bytes[1];
        pend[2] = in_data;
      end
    endcase
    np = held_count + {1'b0, !at_end};
  end

  assign ctl_chain[0]    = ctl;
  assign line_chain[0]   = line_count;
  assign column_chain[0] = column_count;
  assign sline_chain[0]  = start_line;
  assign scol_chain[0]   = start_column;
  assign pos_chain[0]    = 2'd0;

  // Each step classifies one token from where the previous one stopped.
  for (genvar i = 0; i < MAX_RES; i++) begin : g_take
    assign win_chain[i]   = pend >> {pos_chain[i], 3'b000};
    assign avail_chain[i] = np - pos_chain[i];
    assign pos_chain[i+1] = pos_chain[i] + used_chain[i];

    stc_take #(
      .LINE_WIDTH  (LINE_WIDTH),
      .COLUMN_WIDTH(COLUMN_WIDTH)
    ) u_take (
      .ctl_in          (ctl_chain[i]),
      .line_in         (line_chain[i]),
      .column_in       (column_chain[i]),
      .start_line_in   (sline_chain[i]),
      .start_column_in (scol_chain[i]),
      .window          (win_chain[i]),
      .avail           (avail_chain[i]),
      .at_end          (at_end),
      .ctl_out         (ctl_chain[i+1]),
      .line_out        (line_chain[i+1]),
      .column_out      (column_chain[i+1]),
      .start_line_out  (sline_chain[i+1]),
      .start_column_out(scol_chain[i+1]),
      .used            (used_chain[i]),
      .res             (res_chain[i])
    );
  end

  // End of stream counts the terminating zero, plus one column for a dangling escape.
  always_comb begin
    end_sum = {1'b0, column_chain[MAX_RES]} +
              (((ctl_chain[MAX_RES].open_kind == K_STR) && ctl_chain[MAX_RES].escape_pending) ?
               (COLUMN_WIDTH+1)'(2) : (COLUMN_WIDTH+1)'(1));
    end_column = end_sum[COLUMN_WIDTH] ? '1 : end_sum[COLUMN_WIDTH-1:0];
  end

  // Gather the words of all steps in byte order, then the end-of-file word.
  always_comb begin
    slot_res    = '0;
    slot_line   = '0;
    slot_column = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      for (int j = 0; j < MAX_RES; j++) begin
        if (2'(j) < used_chain[i]) begin
          slot_res[2'(int'(pos_chain[i]) + j)]    = res_chain[i][j];
          slot_line[2'(int'(pos_chain[i]) + j)]   = sline_chain[i+1];
          slot_column[2'(int'(pos_chain[i]) + j)] = scol_chain[i+1];
        end
      end
    end
    if (at_end) begin
      slot_res[pos_chain[MAX_RES]].data  = '0;
      slot_res[pos_chain[MAX_RES]].kind  = K_EOF;
      slot_res[pos_chain[MAX_RES]].start = 1'b1;
      slot_res[pos_chain[MAX_RES]].text  = 1'b0;
      if (ctl_chain[MAX_RES].open_kind != K_BLANK) begin
        slot_line[pos_chain[MAX_RES]]   = line_chain[MAX_RES];
        slot_column[pos_chain[MAX_RES]] = end_column;
      end else begin
        slot_line[pos_chain[MAX_RES]]   = sline_chain[MAX_RES];
        slot_column[pos_chain[MAX_RES]] = scol_chain[MAX_RES];
      end
    end
    n_res = pos_chain[MAX_RES] + {1'b0, at_end};
    for (int k = 0; k < MAX_RES; k++) begin
      slot_word[k].res    = slot_res[k];
      slot_word[k].line   = POS_W'(slot_line[k]);
      slot_word[k].column = POS_W'(slot_column[k]);
      slot_word[k].last   = (2'(k) == n_res - 2'd1);
    end
  end

  // Next scanner state: back to reset after end of file, else keep what is left over.
  always_comb begin
    rest              = pend >> {pos_chain[MAX_RES], 3'b000};
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    line_count_next   = line_count;
    column_count_next = column_count;
    ctl_next          = ctl;
    start_line_next   = start_line;
    start_column_next = start_column;
    if (take_item) begin
      if (at_end) begin
        held_count_next   = 2'd0;
        line_count_next   = LINE_WIDTH'(1);
        column_count_next = '0;
        ctl_next          = '0;
        start_line_next   = LINE_WIDTH'(1);
        start_column_next = COLUMN_WIDTH'(1);
      end else begin
        held_bytes_next   = rest[MAX_RES-2:0];
        held_count_next   = np - pos_chain[MAX_RES];
        line_count_next   = line_chain[MAX_RES];
        column_count_next = column_chain[MAX_RES];
        ctl_next          = ctl_chain[MAX_RES];
        start_line_next   = sline_chain[MAX_RES];
        start_column_next = scol_chain[MAX_RES];
      end
    end
  end

  assign fifo_count_next = fifo_count + (take_item ? FIFO_CW'(n_res) : FIFO_CW'(0)) -
                           FIFO_CW'(pop);

  // Control and scanner registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      held_count   <= 2'd0;
      line_count   <= LINE_WIDTH'(1);
      column_count <= '0;
      ctl          <= '0;
      start_line   <= LINE_WIDTH'(1);
      start_column <= COLUMN_WIDTH'(1);
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      fifo_count   <= '0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (take_item) begin
        in_full <= 1'b0;
      end
      held_count   <= held_count_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      ctl          <= ctl_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
      if (take_item) begin
        wr_ptr <= wr_ptr + FIFO_AW'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count_next;
    end
  end

  // Payload registers and queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_data <= s_axis_tdata;
      in_end  <= s_axis_tuser[0];
    end
    held_bytes <= held_bytes_next;
    if (take_item) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < n_res) begin
          fifo_mem[FIFO_AW'(wr_ptr + FIFO_AW'(k))] <= slot_word[k];
        end
      end
    end
  end

  // Output side shows the queue head.
  assign head          = fifo_mem[rd_ptr];
  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata  = {head.column, head.line, head.res.data};
  assign m_axis_tuser  = {head.res.text, head.res.start, head.res.kind};
  assign m_axis_tlast  = head.last;

endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TEXT_WORDS   = 110;
  localparam int BURST_WORDS  = 40;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_ROWS     = 28;

  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CH_NL        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BACKQUOTE = 8'h60;

  // One classified byte as it leaves the block.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              start;
    logic              text;
    logic [POS_W-1:0]  line_no;
    logic [POS_W-1:0]  col_no;
    logic              last;
  } tag_t;

  // One input word; the tagged rows carry a single expected word written out by hand.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              mark;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  line_no;
    logic [POS_W-1:0]  col_no;
  } row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              mark;
  } src_word_t;

  logic                  clk;
  logic                  rst;
  logic                  s_valid;
  logic [BYTE_W-1:0]     s_data;
  logic [IN_USER_W-1:0]  s_user;
  logic                  m_ready;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  script_token_classifier_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Scanner state of the predictor.
  logic [BYTE_W-1:0] la_bytes [2];
  int                la_count;
  logic [POS_W-1:0]  cur_line;
  logic [POS_W-1:0]  cur_col;
  logic [POS_W-1:0]  tok_line;
  logic [POS_W-1:0]  tok_col;
  logic [KIND_W-1:0] open_kind;
  logic [BYTE_W-1:0] quote_ch;
  logic              esc_pend;

  tag_t      step_tags [$];
  tag_t      tags_due [$];
  src_word_t stim_words [$];
  row_t      dir_rows [DIR_ROWS];

  int errors;
  int words_seen;
  int cycle_count;
  bit idle_on;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Character classes.
  function automatic bit is_blank_ch(input logic [BYTE_W-1:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_letter_ch(input logic [BYTE_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit_ch(input logic [BYTE_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_quote_ch(input logic [BYTE_W-1:0] c);
    return c == "\"" || c == "'" || c == CH_BACKQUOTE;
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] c);
    case (c)
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "[":     return K_LBRACK;
      "]":     return K_RBRACK;
      ",":     return K_COMMA;
      ":":     return K_COLON;
      ";":     return K_SEMI;
      "=":     return K_EQUAL;
      default: return K_NONE;
    endcase
  endfunction

  function automatic bit is_raw_ch(input logic [BYTE_W-1:0] c);
    return c != CH_NUL && punct_kind(c) == K_NONE && c != "&" && c != "-" && c != "$" &&
           !is_quote_ch(c) && !is_letter_ch(c) && !is_digit_ch(c) && !is_blank_ch(c);
  endfunction

  function automatic void clear_scanner();
    la_bytes[0] = CH_NUL;
    la_bytes[1] = CH_NUL;
    la_count    = 0;
    cur_line    = 16'd1;
    cur_col     = 16'd0;
    tok_line    = 16'd1;
    tok_col     = 16'd1;
    open_kind   = K_NONE;
    quote_ch    = CH_NUL;
    esc_pend    = 1'b0;
  endfunction

  // Line and column counting, both saturating.
  function automatic void count_ch(input logic [BYTE_W-1:0] c);
    if (c == CH_NL) begin
      if (cur_line != '1) cur_line++;
      cur_col = '0;
    end else if (cur_col != '1) begin
      cur_col++;
    end
  endfunction

  function automatic void put_tag(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] kind,
                                  input logic st, input logic tx);
    tag_t t;
    t.data    = b;
    t.kind    = kind;
    t.start   = st;
    t.text    = tx;
    t.line_no = tok_line;
    t.col_no  = tok_col;
    t.last    = 1'b0;
    step_tags.push_back(t);
  endfunction

  // Classifies the byte at the head of the pending bytes; returns how many bytes it took,
  // or zero when it must wait for more lookahead.
  function automatic int take_byte(input logic [BYTE_W-1:0] c, input logic [BYTE_W-1:0] nx1,
                                   input logic [BYTE_W-1:0] nx2, input int avail,
                                   input logic at_end);
    logic [BYTE_W-1:0] l1;
    logic [BYTE_W-1:0] l2;
    logic              has1;
    logic              has2;
    logic              cont;
    logic [KIND_W-1:0] k;
    l1   = (avail > 1) ? nx1 : CH_NUL;
    l2   = (avail > 2) ? nx2 : CH_NUL;
    has1 = avail > 1 || at_end;
    has2 = avail > 2 || at_end;

    // Inside a string every byte is string text, except the closing quote.
    if (open_kind == K_STR) begin
      count_ch(c);
      if (esc_pend) begin
        esc_pend = 1'b0;
        put_tag(c, K_STR, 1'b0, 1'b1);
        return 1;
      end
      if (c == quote_ch) begin
        open_kind = K_NONE;
        put_tag(c, K_STR, 1'b0, 1'b0);
        return 1;
      end
      if (c == "\\") esc_pend = 1'b1;
      put_tag(c, K_STR, 1'b0, 1'b1);
      return 1;
    end

    cont = (open_kind == K_NUM && (is_digit_ch(c) || c == ".")) ||
           (open_kind == K_ID && (is_letter_ch(c) || is_digit_ch(c))) ||
           (open_kind == K_RAW && is_raw_ch(c));
    if (cont) begin
      count_ch(c);
      put_tag(c, open_kind, 1'b0, 1'b1);
      return 1;
    end

    // Two- and three-byte tokens wait for their lookahead.
    if ((c == "{" || c == "}" || c == "-") && !has1) return 0;
    if (c == "&" && (!has1 || (l1 == "-" && !has2))) return 0;

    count_ch(c);
    if (open_kind != K_BLANK) open_kind = K_NONE;
    if (open_kind == K_NONE) begin
      tok_line = cur_line;
      tok_col  = cur_col;
    end
    if (is_blank_ch(c)) begin
      open_kind = K_BLANK;
      put_tag(c, K_SKIP, 1'b0, 1'b0);
      return 1;
    end
    open_kind = K_NONE;

    if ((c == "{" || c == "}") && l1 == c) begin
      k = (c == "{") ? K_LL : K_RR;
      put_tag(c, k, 1'b1, 1'b1);
      count_ch(l1);
      put_tag(l1, k, 1'b0, 1'b1);
      return 2;
    end
    if (c == "$") begin
      put_tag(c, K_DOLLAR, 1'b1, 1'b1);
      return 1;
    end
    if (c == "&" && l1 == "-" && l2 == ">") begin
      put_tag(c, K_BIND, 1'b1, 1'b1);
      count_ch(l1);
      put_tag(l1, K_BIND, 1'b0, 1'b1);
      count_ch(l2);
      put_tag(l2, K_BIND, 1'b0, 1'b1);
      return 3;
    end
    if (c == "-" && l1 == ">") begin
      put_tag(c, K_ARROW, 1'b1, 1'b1);
      count_ch(l1);
      put_tag(l1, K_ARROW, 1'b0, 1'b1);
      return 2;
    end
    k = punct_kind(c);
    if (k != K_NONE) begin
      put_tag(c, k, 1'b1, 1'b1);
      return 1;
    end
    if (is_quote_ch(c)) begin
      open_kind = K_STR;
      quote_ch  = c;
      esc_pend  = 1'b0;
      put_tag(c, K_STR, 1'b1, 1'b0);
      return 1;
    end
    if (is_digit_ch(c)) begin
      open_kind = K_NUM;
      put_tag(c, K_NUM, 1'b1, 1'b1);
      return 1;
    end
    if (is_letter_ch(c)) begin
      open_kind = K_ID;
      put_tag(c, K_ID, 1'b1, 1'b1);
      return 1;
    end
    // A lone ampersand or minus is a one-byte raw token that opens no run.
    if (is_raw_ch(c)) open_kind = K_RAW;
    put_tag(c, K_RAW, 1'b1, 1'b1);
    return 1;
  endfunction

  // Predicts the words that one accepted input word releases into step_tags.
  function automatic void scan_word(input logic [BYTE_W-1:0] b, input logic mark);
    logic [BYTE_W-1:0] pend [5];
    int                np;
    int                pos;
    int                k;
    int                i;
    logic              at_end;
    tag_t              t;
    at_end = mark || b == CH_NUL;
    step_tags.delete();
    for (i = 0; i < 5; i++) pend[i] = CH_NUL;
    np = 0;
    for (i = 0; i < la_count; i++) begin
      pend[np] = la_bytes[i];
      np++;
    end
    if (!at_end) begin
      pend[np] = b;
      np++;
    end

    pos = 0;
    k   = 1;
    while (pos < np && k != 0) begin
      k   = take_byte(pend[pos], pend[pos+1], pend[pos+2], np - pos, at_end);
      pos += k;
    end

    if (at_end) begin
      // A backslash left open at the end costs one extra column.
      if (open_kind == K_STR && esc_pend) count_ch(CH_NUL);
      count_ch(CH_NUL);
      if (open_kind != K_BLANK) open_kind = K_NONE;
      if (open_kind == K_NONE) begin
        tok_line = cur_line;
        tok_col  = cur_col;
      end
      put_tag(CH_NUL, K_EOF, 1'b1, 1'b0);
      clear_scanner();
    end else begin
      la_count = 0;
      while (pos < np && la_count < 2) begin
        la_bytes[la_count] = pend[pos];
        la_count++;
        pos++;
      end
    end

    if (step_tags.size() != 0) begin
      t      = step_tags.pop_back();
      t.last = 1'b1;
      step_tags.push_back(t);
    end
  endfunction

  // Offers one word and returns at the edge where it is accepted.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic mark);
    if (idle_on && $urandom_range(99) < 37) begin
      s_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= mark;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic feed_word(input logic [BYTE_W-1:0] b, input logic mark);
    send_word(b, mark);
    scan_word(b, mark);
    foreach (step_tags[j]) tags_due.push_back(step_tags[j]);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  // Compares one accepted output word with the oldest prediction.
  task automatic check_word();
    tag_t want;
    tag_t got;
    got.data    = m_axis_tdata[7:0];
    got.line_no = m_axis_tdata[23:8];
    got.col_no  = m_axis_tdata[39:24];
    got.kind    = m_axis_tuser[4:0];
    got.start   = m_axis_tuser[5];
    got.text    = m_axis_tuser[6];
    got.last    = m_axis_tlast;
    words_seen++;
    if (tags_due.size() == 0) begin
      $display("%0t: unexpected word, expected none, got byte %0d kind %0d",
               $time, got.data, got.kind);
      errors++;
    end else begin
      want = tags_due.pop_front();
      if (got.data !== want.data) report_field("out_byte", 32'(want.data), 32'(got.data));
      if (got.kind !== want.kind) report_field("token_kind", 32'(want.kind), 32'(got.kind));
      if (got.start !== want.start) begin
        report_field("token_start", 32'(want.start), 32'(got.start));
      end
      if (got.text !== want.text) report_field("in_text", 32'(want.text), 32'(got.text));
      if (got.line_no !== want.line_no) begin
        report_field("token_line", 32'(want.line_no), 32'(got.line_no));
      end
      if (got.col_no !== want.col_no) begin
        report_field("token_column", 32'(want.col_no), 32'(got.col_no));
      end
      if (got.last !== want.last) report_field("run_last", 32'(want.last), 32'(got.last));
    end
  endtask

  // Random text generation.
  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    src_word_t w;
    w.data = b;
    w.mark = 1'b0;
    stim_words.push_back(w);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_letter(input bit with_digits);
    int n;
    n = $urandom_range(with_digits ? 62 : 52);
    if (n < 26) return BYTE_W'("a" + n);
    if (n < 52) return BYTE_W'("A" + (n - 26));
    if (n == 52) return "_";
    return BYTE_W'("0" + (n - 53));
  endfunction

  function automatic void add_token();
    logic [BYTE_W-1:0] q;
    logic [BYTE_W-1:0] b;
    src_word_t         w;
    int                n;
    case ($urandom_range(15))
      0: begin
        add_byte(pick_letter(1'b0));
        repeat ($urandom_range(5)) add_byte(pick_letter(1'b1));
      end
      1: begin
        add_byte(BYTE_W'("0" + $urandom_range(9)));
        repeat ($urandom_range(4)) add_byte(($urandom_range(3) == 0) ? "." :
                                            BYTE_W'("0" + $urandom_range(9)));
      end
      2: begin
        n = $urandom_range(2);
        q = (n == 0) ? "\"" : (n == 1) ? "'" : CH_BACKQUOTE;
        add_byte(q);
        repeat ($urandom_range(6)) begin
          if ($urandom_range(4) == 0) begin
            add_byte("\\");
            add_byte(BYTE_W'($urandom_range(1, 255)));
          end else begin
            do b = BYTE_W'($urandom_range(1, 255)); while (b == q);
            add_byte(b);
          end
        end
        if ($urandom_range(9) != 0) add_byte(q);
      end
      3: begin
        case ($urandom_range(9))
          0: add_byte("{");
          1: add_byte("}");
          2: add_byte("(");
          3: add_byte(")");
          4: add_byte("[");
          5: add_byte("]");
          6: add_byte(",");
          7: add_byte(":");
          8: add_byte(";");
          default: add_byte("=");
        endcase
      end
      4: begin
        b = $urandom_range(1) ? "{" : "}";
        add_byte(b);
        add_byte(b);
      end
      5: begin
        add_byte("&");
        add_byte("-");
        add_byte(">");
      end
      6: begin
        add_byte("-");
        add_byte(">");
      end
      7: add_byte($urandom_range(1) ? "&" : "-");
      8: begin
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(5);
          add_byte((n == 0) ? " " : BYTE_W'(9 + n - 1));
        end
      end
      9: begin
        repeat ($urandom_range(1, 3)) begin
          do b = BYTE_W'($urandom_range(1, 255)); while (!is_raw_ch(b));
          add_byte(b);
        end
      end
      10: add_byte("$");
      11: add_byte(BYTE_W'($urandom_range(1, 255)));
      12: begin
        // End of stream, by the end mark (byte ignored) or by a zero byte.
        w.data = BYTE_W'($urandom_range(255));
        w.mark = 1'($urandom_range(1));
        if (!w.mark) w.data = CH_NUL;
        stim_words.push_back(w);
      end
      default: add_byte(" ");
    endcase
  endfunction

  // Sink: random backpressure and one long hold-off.
  initial begin
    m_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_ready) check_word();
      if (!hold_done && words_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_ready <= !(idle_on && $urandom_range(99) < 37);
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count,
             tags_due.size());
    $display("tb failed");
    $finish;
  end

  // Source: directed rows, random text, then a burst at full rate.
  initial begin
    tag_t      typed_tag;
    src_word_t w;
    int        i;
    errors     = 0;
    words_seen = 0;
    hold_done  = 1'b0;
    idle_on    = 1'b1;
    clear_scanner();
    rst     <= 1'b1;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= '0;

    dir_rows = '{
      '{CH_NUL, 1'b1, 1'b1, K_EOF,    16'd1, 16'd1},  // end mark right after reset
      '{"$",    1'b0, 1'b1, K_DOLLAR, 16'd1, 16'd1},
      '{CH_NUL, 1'b0, 1'b1, K_EOF,    16'd1, 16'd2},  // zero byte ends the stream
      '{8'hFF,  1'b0, 1'b1, K_RAW,    16'd1, 16'd1},
      '{8'hAB,  1'b1, 1'b1, K_EOF,    16'd1, 16'd2},  // byte under the end mark is ignored
      '{"{",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"{",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"}",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"}",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"&",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"-",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{">",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"-",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{">",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{CH_NL,  1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"\"",   1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"\\",   1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"\"",   1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"\"",   1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"9",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{".",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"_",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"&",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"-",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{CH_NUL, 1'b1, 1'b0, K_NONE,   16'd0, 16'd0},  // flushes a held "&-" as two raw bytes
      '{"'",    1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{"\\",   1'b0, 1'b0, K_NONE,   16'd0, 16'd0},
      '{CH_NUL, 1'b1, 1'b0, K_NONE,   16'd0, 16'd0}   // backslash open at the end
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: typed rows carry their one word, the rest go through the predictor.
    for (i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].data, dir_rows[i].mark);
      scan_word(dir_rows[i].data, dir_rows[i].mark);
      if (dir_rows[i].typed) begin
        typed_tag.data    = (dir_rows[i].kind == K_EOF) ? CH_NUL : dir_rows[i].data;
        typed_tag.kind    = dir_rows[i].kind;
        typed_tag.start   = 1'b1;
        typed_tag.text    = dir_rows[i].kind != K_EOF;
        typed_tag.line_no = dir_rows[i].line_no;
        typed_tag.col_no  = dir_rows[i].col_no;
        typed_tag.last    = 1'b1;
        tags_due.push_back(typed_tag);
      end else begin
        foreach (step_tags[j]) tags_due.push_back(step_tags[j]);
      end
    end

    // Pause the source until every predicted word has come out.
    s_valid <= 1'b0;
    do @(posedge clk); while (tags_due.size() != 0);

    // Random token text, closed by an end mark.
    while (stim_words.size() < TEXT_WORDS) add_token();
    w.data = BYTE_W'($urandom_range(255));
    w.mark = 1'b1;
    stim_words.push_back(w);
    while (stim_words.size() != 0) begin
      w = stim_words.pop_front();
      feed_word(w.data, w.mark);
    end

    // A burst of random text with no idling on either side.
    idle_on = 1'b0;
    while (stim_words.size() < BURST_WORDS) add_token();
    w.data = BYTE_W'($urandom_range(255));
    w.mark = 1'b1;
    stim_words.push_back(w);
    while (stim_words.size() != 0) begin
      w = stim_words.pop_front();
      feed_word(w.data, w.mark);
    end
    idle_on = 1'b1;

    s_valid <= 1'b0;
    do @(posedge clk); while (tags_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
